// File: rtl/core/rmws_pkg.sv
// rmws_pkg: shared constants for the rna motif window scan
// window geometry, pair and site positions, pairing table reset value
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rmws_pkg;

   localparam int unsigned WIN_LEN   = 39;
   localparam int unsigned NUM_PAIRS = 8;
   localparam int unsigned NUM_SITES = 13;
   localparam int unsigned POS_W     = 6;   // index into the window
   localparam int unsigned COUNT_W   = 6;
   localparam int unsigned SCORE_W   = 5;
   localparam int unsigned TABLE_W   = 16;
   localparam int unsigned BASE_W    = 2;
   localparam int unsigned RESULT_W  = 6;

   localparam logic [COUNT_W-1:0] WIN_COUNT  = COUNT_W'(WIN_LEN);
   localparam logic [SCORE_W-1:0] BEST_RESET = '1;
   localparam logic [TABLE_W-1:0] TABLE_RESET = 16'hA5B7;

   // window index 0 is the oldest nucleotide
   localparam logic [POS_W-1:0] PAIR_FIRST [NUM_PAIRS] =
      '{6'd0, 6'd1, 6'd2, 6'd5, 6'd6, 6'd7, 6'd8, 6'd25};
   localparam logic [POS_W-1:0] PAIR_SECOND [NUM_PAIRS] =
      '{6'd38, 6'd37, 6'd36, 6'd16, 6'd15, 6'd14, 6'd13, 6'd30};

   localparam logic [POS_W-1:0] SITE_POS [NUM_SITES] =
      '{6'd3, 6'd17, 6'd18, 6'd19, 6'd20, 6'd22, 6'd23, 6'd24,
        6'd31, 6'd32, 6'd33, 6'd34, 6'd35};
   localparam logic [BASE_W-1:0] SITE_WANT [NUM_SITES] =
      '{2'd3, 2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2,
        2'd1, 2'd2, 2'd0, 2'd0, 2'd0};

endpackage

`default_nettype wire

// File: rtl/core/rna_motif_window_scan.sv
// rna_motif_window_scan: streaming motif scan over a 39-nucleotide window
// depends on rmws_pkg for window geometry and motif positions
`timescale 1ns / 1ps
`default_nettype none

// result path: a request marked last passes the stage register and then the result
//   register before its result shows on rsp; it shows later only while rsp_tready holds the result off
// throughput: one request per clock unless a result waits on rsp_tready; the score
//   is an adder tree over the window register between the stage and result registers
// reset: synchronous, active high; clears count, best score and valid flags,
//   loads the pairing table with 0xA5B7; window not cleared

module rna_motif_window_scan (
   input  wire         clock,
   input  wire         reset,
   // configuration
   input  wire         csr_wen,
   input  wire  [15:0] csr_wdata,   // pair_mismatch_table
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [1:0] base, [7:2] zero
   input  wire         req_tlast,   // last nucleotide of the sequence
   // result channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata    // [5:0] min_mismatch or short length, [7:6] zero
);

   // pairing table register
   logic [rmws_pkg::TABLE_W-1:0] table_ff;

   // window shift line, index 0 oldest
   logic [rmws_pkg::BASE_W-1:0] window_ff [rmws_pkg::WIN_LEN];

   // sequence count, updated at accept time
   logic [rmws_pkg::COUNT_W-1:0] count_ff, count_in;

   // stage register: one request whose window is now in window_ff
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_last_ff;
   logic                         s1_scored_ff;   // window full for this request
   logic [rmws_pkg::COUNT_W-1:0] s1_count_ff;

   // running minimum for the sequence
   logic [rmws_pkg::SCORE_W-1:0] best_ff, best_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rmws_pkg::RESULT_W-1:0] rsp_data_ff;

   logic                          req_accept;
   logic                          advance;      // stage moves into the result side
   logic [rmws_pkg::SCORE_W-1:0]  score;
   logic [rmws_pkg::SCORE_W-1:0]  best_with_score;
   logic [rmws_pkg::RESULT_W-1:0] result_value;

   // one bit per pair or site that misses, padded to whole groups of three
   logic [23:0] miss;
   logic [1:0]  sum_l1 [8];
   logic [2:0]  sum_l2 [4];
   logic [3:0]  sum_l3 [2];

   // stage can drain when the result slot is free or being taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // saturating count, cleared after a last request
   always_comb begin
      if (req_tlast) begin
         count_in = '0;
      end else if (count_ff < rmws_pkg::WIN_COUNT) begin
         count_in = count_ff + 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   // mismatch bits of the window as it stands after the staged request
   always_comb begin
      logic [rmws_pkg::BASE_W-1:0] a;
      logic [rmws_pkg::BASE_W-1:0] b;
      miss = '0;
      for (int i = 0; i < rmws_pkg::NUM_PAIRS; i++) begin
         a = window_ff[rmws_pkg::PAIR_FIRST[i]];
         b = window_ff[rmws_pkg::PAIR_SECOND[i]];
         miss[i] = table_ff[{a, b}];
      end
      for (int i = 0; i < rmws_pkg::NUM_SITES; i++) begin
         miss[rmws_pkg::NUM_PAIRS + i] =
            (window_ff[rmws_pkg::SITE_POS[i]] != rmws_pkg::SITE_WANT[i]);
      end
   end

   // balanced count of the mismatch bits
   always_comb begin
      for (int g = 0; g < 8; g++) begin
         sum_l1[g] = 2'(miss[3*g]) + 2'(miss[3*g+1]) + 2'(miss[3*g+2]);
      end
      for (int g = 0; g < 4; g++) begin
         sum_l2[g] = 3'(sum_l1[2*g]) + 3'(sum_l1[2*g+1]);
      end
      for (int g = 0; g < 2; g++) begin
         sum_l3[g] = 4'(sum_l2[2*g]) + 4'(sum_l2[2*g+1]);
      end
      score = rmws_pkg::SCORE_W'(sum_l3[0]) + rmws_pkg::SCORE_W'(sum_l3[1]);
   end

   // fold this score into the minimum when the window was full
   assign best_with_score = (s1_scored_ff && (score < best_ff)) ? score : best_ff;

   // short sequences report their length instead of a score
   assign result_value = s1_scored_ff ? rmws_pkg::RESULT_W'(best_with_score)
                                      : s1_count_ff;

   always_comb begin
      best_in = best_ff;
      if (s1_valid_ff && advance) begin
         best_in = s1_last_ff ? rmws_pkg::BEST_RESET : best_with_score;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (s1_valid_ff && advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         table_ff     <= rmws_pkg::TABLE_RESET;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         best_ff      <= rmws_pkg::BEST_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            table_ff <= csr_wdata;
         end
         if (req_accept) begin
            count_ff <= count_in;
         end
         s1_valid_ff  <= s1_valid_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: window shift, stage fields, result value
   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int i = 0; i < rmws_pkg::WIN_LEN - 1; i++) begin
            window_ff[i] <= window_ff[i+1];
         end
         window_ff[rmws_pkg::WIN_LEN-1] <= req_tdata[rmws_pkg::BASE_W-1:0];
         s1_last_ff   <= req_tlast;
         s1_scored_ff <= (count_ff >= rmws_pkg::WIN_COUNT - 1'b1);
         s1_count_ff  <= (count_ff < rmws_pkg::WIN_COUNT) ? count_ff + 1'b1 : count_ff;
      end
      if (s1_valid_ff && advance && s1_last_ff) begin
         rsp_data_ff <= result_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

endmodule

`default_nettype wire

// File: rtl/core/rmws_checker.sv
// rmws_checker: port-level checks for rna_motif_window_scan
// bound to the top level below; uses no package
`timescale 1ns / 1ps
`default_nettype none

module rmws_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [7:0]  rsp_tdata
);

   // no result survives a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // a score or a short length never reaches the window size
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:0] <= 6'd38)
      else $error("result out of range");

   // padding bits stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:6] == 2'b00)
      else $error("result padding not zero");

endmodule

bind rna_motif_window_scan rmws_checker u_rmws_checker (.*);

`default_nettype wire
